// ----- sv/lcpr_pkg.sv -----
// Package for the length/checksum packet receiver.
// Holds the shared types, status and command codes, and constants; no dependencies.
`default_nettype none

package lcpr_pkg;

	localparam int unsigned HDR_BYTES = 3;
	localparam int unsigned SUM_W     = 7;
	localparam int unsigned TICK_W    = 24;

	localparam logic [TICK_W-1:0] TIMEOUT_RST = 24'd1000000;

	typedef enum logic {
		CMD_BYTE = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_GOOD    = 2'd0,
		ST_BAD_SUM = 2'd1,
		ST_BAD_LEN = 2'd2,
		ST_TIMEOUT = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t       command;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [7:0] byte_index;
		logic       last;
		status_t    status;
	} res_item_t;

	// Result handed from the core to the output register
	typedef struct packed {
		logic      load;
		res_item_t item;
	} res_req_t;

endpackage

`default_nettype wire

// ----- sv/lcpr_ifs.sv -----
// Channel interfaces of the packet receiver: byte requests, results, configuration.
// Depends on nothing; widths follow the field widths of the block.
`default_nettype none

interface lcpr_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] rx_byte;

	modport source (output valid, output command, output rx_byte, input ready);
	modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface lcpr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [7:0] byte_index;
	logic       last;
	logic [1:0] status;

	modport source (output valid, output out_byte, output byte_index, output last,
		output status, input ready);
	modport sink   (input valid, input out_byte, input byte_index, input last,
		input status, output ready);
endinterface

interface lcpr_cfg_if;
	logic        valid;
	logic        ready;
	logic [23:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/lcpr_in_stage.sv -----
// Input register of the packet receiver: holds one byte or tick request.
// Depends on lcpr_pkg and lcpr_in_if.
`default_nettype none

module lcpr_in_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	lcpr_in_if.sink                req,
	input  wire logic              take,
	output logic                   valid_s1,
	output lcpr_pkg::in_item_t     item_s1
);

	// Accept whenever the held request is empty or leaves this cycle
	assign req.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1.command <= lcpr_pkg::cmd_t'(req.command);
			item_s1.rx_byte <= req.rx_byte;
		end
	end

endmodule

`default_nettype wire

// ----- sv/lcpr_core.sv -----
// Packet state and per-request framing logic of the packet receiver.
// Depends on lcpr_pkg and lcpr_cfg_if; holds the timeout register.
`default_nettype none

module lcpr_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	lcpr_cfg_if.sink               cfg,
	input  wire logic              valid_s1,
	input  wire lcpr_pkg::in_item_t item_s1,
	input  wire logic              out_free,
	output logic                   take,
	output lcpr_pkg::res_req_t     res
);

	localparam logic [7:0] LEN_IDX = 8'(lcpr_pkg::HDR_BYTES - 1);
	localparam logic [7:0] MIN_LEN = 8'(lcpr_pkg::HDR_BYTES);

	logic [7:0]                     count_q, len_q;
	logic [lcpr_pkg::SUM_W-1:0]     sum_q;
	logic [lcpr_pkg::TICK_W-1:0]    idle_q, timeout_q;

	logic [7:0]                     count_n, len_n, len_eff, b;
	logic [lcpr_pkg::SUM_W-1:0]     sum_n;
	logic [lcpr_pkg::TICK_W-1:0]    idle_n, ticks_inc;
	logic                           has_res;
	lcpr_pkg::res_item_t            item;

	assign cfg.ready = 1'b1;
	assign b         = item_s1.rx_byte;
	assign ticks_inc = idle_q + 24'd1;
	assign len_eff   = (count_q == LEN_IDX) ? b : len_q;

	always_comb begin
		count_n = count_q;
		len_n   = len_q;
		sum_n   = sum_q;
		idle_n  = idle_q;
		has_res = 1'b0;
		item    = '{out_byte: 8'd0, byte_index: count_q, last: 1'b0,
			status: lcpr_pkg::ST_GOOD};
		if (item_s1.command == lcpr_pkg::CMD_TICK) begin
			if (count_q != 8'd0) begin
				if (ticks_inc >= timeout_q || ticks_inc == '0) begin
					// drop the partial packet
					has_res     = 1'b1;
					item.last   = 1'b1;
					item.status = lcpr_pkg::ST_TIMEOUT;
					count_n     = '0;
					len_n       = '0;
					sum_n       = '0;
					idle_n      = '0;
				end else begin
					idle_n = ticks_inc;
				end
			end
		end else begin
			has_res       = 1'b1;
			item.out_byte = b;
			idle_n        = '0;
			if (count_q == LEN_IDX && b < MIN_LEN) begin
				item.last   = 1'b1;
				item.status = lcpr_pkg::ST_BAD_LEN;
				count_n     = '0;
				len_n       = '0;
				sum_n       = '0;
			end else if (count_q >= LEN_IDX &&
					({1'b0, count_q} + 9'd1) == {1'b0, len_eff}) begin
				// checksum byte
				item.last   = 1'b1;
				item.status = (b == {1'b0, sum_q}) ? lcpr_pkg::ST_GOOD
					: lcpr_pkg::ST_BAD_SUM;
				count_n     = '0;
				len_n       = '0;
				sum_n       = '0;
			end else begin
				len_n   = len_eff;
				sum_n   = sum_q + b[lcpr_pkg::SUM_W-1:0];
				count_n = count_q + 8'd1;
			end
		end
	end

	assign take     = valid_s1 && (!has_res || out_free);
	assign res.load = take && has_res;
	assign res.item = item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			len_q     <= '0;
			sum_q     <= '0;
			idle_q    <= '0;
			timeout_q <= lcpr_pkg::TIMEOUT_RST;
		end else begin
			if (take) begin
				count_q <= count_n;
				len_q   <= len_n;
				sum_q   <= sum_n;
				idle_q  <= idle_n;
			end
			if (cfg.valid) begin
				timeout_q <= cfg.data;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/lcpr_out_reg.sv -----
// Result register of the packet receiver: holds one result until taken.
// Depends on lcpr_pkg and lcpr_out_if.
`default_nettype none

module lcpr_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lcpr_pkg::res_req_t res,
	output logic                   out_free,
	lcpr_out_if.source             rsp
);

	logic                 valid_q;
	lcpr_pkg::res_item_t  item_q;

	assign out_free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res.load;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			item_q <= res.item;
		end
	end

	assign rsp.valid      = valid_q;
	assign rsp.out_byte   = item_q.out_byte;
	assign rsp.byte_index = item_q.byte_index;
	assign rsp.last       = item_q.last;
	assign rsp.status     = item_q.status;

endmodule

`default_nettype wire

// ----- sv/length_checksum_packet_receiver_top.sv -----
// Length/checksum packet receiver, top level.
// A request is registered in the input stage and its result in the result register.
// Throughput: one request per cycle while the result register can take a result.
// A tick that gives no result still passes the core but needs no free result register.
// Reset (arst_n low, asynchronous) empties both registers, clears the packet
// state and sets the timeout to 1000000 ticks; no clearing pass follows.
`default_nettype none

module length_checksum_packet_receiver_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lcpr_in_if.sink    byte_req,
	lcpr_out_if.source result,
	lcpr_cfg_if.sink   cfg
);

	// Stage 1 holds the request; the core decides on it and the result register
	// takes the outcome in the same cycle. The core only advances when the
	// result register can take a result, or when no result is due (idle ticks).
	logic                valid_s1;
	lcpr_pkg::in_item_t  item_s1;
	logic                take;
	logic                out_free;
	lcpr_pkg::res_req_t  res;

	lcpr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (byte_req),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// Framing, checksum and timeout tracking
	lcpr_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1),
		.out_free (out_free),
		.take     (take),
		.res      (res)
	);

	// Hold each result until the sink takes it
	lcpr_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.out_free (out_free),
		.rsp      (result)
	);

`ifndef SYNTHESIS
	// A loaded result shows up on the next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		res.load |=> result.valid)
		else $error("loaded result not presented");

	// Results that do not end a packet are always good
	a_mid_good: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.last |-> result.status == lcpr_pkg::ST_GOOD)
		else $error("status set on a non-final byte");

	// A timeout result carries a zero byte and ends the packet
	a_timeout_form: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status == lcpr_pkg::ST_TIMEOUT
		|-> result.last && result.out_byte == 8'd0)
		else $error("malformed timeout result");

	// Back-pressure on requests only while stage 1 is full
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_req.ready |-> valid_s1)
		else $error("request stalled with empty stage");
`endif

endmodule

`default_nettype wire
